>>> rtl/dsh_pkg.sv
// shared types and constants of the decimated sample histogram
package dsh_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int OUT_BITS     = 24;
  localparam int SKIP_BITS    = 16;
  localparam int TICK_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SKIP_COUNT    = 2'd0,
    CFG_MEASURE_TICKS = 2'd1
  } cfg_reg_e;

  // action codes of an input beat
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // classified item passed from front to back
  typedef struct packed {
    logic                   is_read;
    logic [SAMPLE_BITS-1:0] bin;
    logic                   binned;
    logic                   done;
  } mid_item_t;

  // one result beat
  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                binned;
    logic                done;
  } result_t;

endpackage

>>> rtl/decimated_sample_histogram.sv
// top level of the decimated sample histogram
//
// usage:
//   input queue side: drive action_i, sample_i, read_bin_i with push; a beat
//   is taken at a clock edge where push is high and full is low. action 0
//   is a converter sample, action 1 reads one bin count.
//   result queue side: while empty is low the oldest result sits on
//   bin_value_o, sample_binned_o, measurement_done_o; pop takes it.
//   exactly one result beat per input beat, in order.
//   configuration: cfg_we_i with cfg_idx_i 0 (skip_count) or 1
//   (measure_ticks) and cfg_data_i, only while the block is idle.
// throughput: one beat per cycle while the result queue drains and no clear
//   pass runs; a forwarding register serves back-to-back bin memory hits.
// path: a beat passes the item queue, the s1 register, then the result queue.
// reset: the bin memory is swept to zero one bin per cycle over all bins,
//   with full held high; config writes are still taken.
// stalls: a 4-deep result queue and a 2-deep item queue absorb a stalled
//   receiver; once they fill, full goes high and input is held off.
module decimated_sample_histogram #(
  parameter int BIN_BITS   = 10,
  parameter int COUNT_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [dsh_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dsh_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // input queue side
  input  logic                               push,
  output logic                               full,
  input  logic                               action_i,
  input  logic [dsh_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [dsh_pkg::SAMPLE_BITS-1:0]    read_bin_i,
  // result queue side
  output logic                               empty,
  input  logic                               pop,
  output logic [dsh_pkg::OUT_BITS-1:0]       bin_value_o,
  output logic                               sample_binned_o,
  output logic                               measurement_done_o
);

  import dsh_pkg::*;

  localparam int MID_DEPTH = 2;

  // front to back item queue
  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_wr, mid_rd;
  logic      clear_busy;
  result_t   result;

  dsh_front #(
    .BIN_BITS (BIN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .action_i   (action_i),
    .sample_i   (sample_i),
    .read_bin_i (read_bin_i),
    .stall_i    (mid_full || clear_busy),
    .full_o     (full),
    .mid_push_o (mid_push),
    .mid_item_o (mid_wr)
  );

  // count output left open, the back end paces itself on its own queue
  dsh_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rd),
    .empty_o (mid_empty),
    .count_o ()
  );

  dsh_back #(
    .BIN_BITS   (BIN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_item_i   (mid_rd),
    .mid_pop_o    (mid_pop),
    .clear_busy_o (clear_busy),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (result)
  );

  assign bin_value_o        = result.value;
  assign sample_binned_o    = result.binned;
  assign measurement_done_o = result.done;

endmodule

>>> rtl/dsh_ram.sv
// generic single write, single read ram with registered read data
module dsh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dsh_fifo.sv
// small first-word fall-through queue in flip-flops
module dsh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/dsh_front.sv
// front end: accepts beats, runs decimation and tick counters, classifies items
module dsh_front #(
  parameter int BIN_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dsh_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dsh_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               push_i,
  input  logic                               action_i,
  input  logic [dsh_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic [dsh_pkg::SAMPLE_BITS-1:0]    read_bin_i,
  input  logic                               stall_i,
  output logic                               full_o,
  output logic                               mid_push_o,
  output dsh_pkg::mid_item_t                 mid_item_o
);

  import dsh_pkg::*;

  localparam int SHIFT = SAMPLE_BITS - BIN_BITS;

  logic [SKIP_BITS-1:0] skip_count_q, skip_count_d;
  logic [SKIP_BITS-1:0] skip_left_q, skip_left_d;
  logic [TICK_BITS-1:0] ticks_left_q, ticks_left_d;
  logic                 done_q, done_d;
  logic                 accept;
  logic                 keep;

  assign full_o     = stall_i;
  assign accept     = push_i && !stall_i;
  assign mid_push_o = accept;
  assign keep       = (skip_left_q == '0);

  always_comb begin
    skip_count_d = skip_count_q;
    skip_left_d  = skip_left_q;
    ticks_left_d = ticks_left_q;
    done_d       = done_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SKIP_COUNT: begin
          skip_count_d = cfg_data_i[SKIP_BITS-1:0];
          skip_left_d  = cfg_data_i[SKIP_BITS-1:0];
        end
        CFG_MEASURE_TICKS: begin
          ticks_left_d = cfg_data_i[TICK_BITS-1:0];
          done_d       = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (accept && (action_i == ACT_SAMPLE)) begin
      skip_left_d = keep ? skip_count_q : skip_left_q - 1'b1;
      if (!done_q) begin
        // a counter already at zero stays there and just raises done
        ticks_left_d = (ticks_left_q != '0) ? ticks_left_q - 1'b1 : '0;
        done_d       = (ticks_left_d == '0);
      end
    end
  end

  always_comb begin
    mid_item_o.is_read = (action_i == ACT_READ);
    if (action_i == ACT_READ) begin
      mid_item_o.bin    = SAMPLE_BITS'(read_bin_i[BIN_BITS-1:0]);
      mid_item_o.binned = 1'b0;
    end else begin
      mid_item_o.bin    = SAMPLE_BITS'(sample_i >> SHIFT);
      mid_item_o.binned = keep;
    end
    mid_item_o.done = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_count_q <= '0;
      skip_left_q  <= '0;
      ticks_left_q <= TICK_BITS'(1);
      done_q       <= 1'b0;
    end else begin
      skip_count_q <= skip_count_d;
      skip_left_q  <= skip_left_d;
      ticks_left_q <= ticks_left_d;
      done_q       <= done_d;
    end
  end

endmodule

>>> rtl/dsh_back.sv
// back end: bin read-modify-write with forwarding, clearing pass, result queue
module dsh_back #(
  parameter int BIN_BITS   = 10,
  parameter int COUNT_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mid_empty_i,
  input  dsh_pkg::mid_item_t mid_item_i,
  output logic               mid_pop_o,
  output logic               clear_busy_o,
  input  logic               pop_i,
  output logic               empty_o,
  output dsh_pkg::result_t   result_o
);

  import dsh_pkg::*;

  localparam int NUM_BINS  = 1 << BIN_BITS;
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);
  localparam int WIDE_BITS = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

  logic                  clr_q, clr_d;
  logic [BIN_BITS-1:0]   clr_addr_q, clr_addr_d;
  logic                  s1_v_q;
  mid_item_t             s1_item_q;
  logic [BIN_BITS-1:0]   s1_bin;
  logic                  fwd_v_q;
  logic [BIN_BITS-1:0]   fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic                  ram_we;
  logic [BIN_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur;
  logic [WIDE_BITS-1:0]  cur_wide;
  logic                  issue;
  logic                  out_full;
  logic [OCW-1:0]        out_cnt;
  result_t               res;

  // issue only when the result queue has room for everything in flight
  assign issue = !mid_empty_i && !clr_q &&
                 ((OCW+1)'(out_cnt) + (OCW+1)'(s1_v_q) < (OCW+1)'(OUT_DEPTH));
  assign mid_pop_o    = issue;
  assign clear_busy_o = clr_q;
  assign s1_bin       = s1_item_q.bin[BIN_BITS-1:0];

  // the write made at the same edge as our read is not in the read data
  assign cur      = (fwd_v_q && (fwd_addr_q == s1_bin)) ? fwd_data_q : ram_rdata;
  assign cur_wide = WIDE_BITS'(cur);

  assign ram_we    = clr_q || (s1_v_q && !s1_item_q.is_read && s1_item_q.binned);
  assign ram_waddr = clr_q ? clr_addr_q : s1_bin;
  assign ram_wdata = clr_q ? '0 : cur + 1'b1;

  always_comb begin
    res.value  = s1_item_q.is_read ? cur_wide[OUT_BITS-1:0] : '0;
    res.binned = s1_item_q.binned;
    res.done   = s1_item_q.done;
  end

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == BIN_BITS'(NUM_BINS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_v_q     <= 1'b0;
      fwd_v_q    <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      s1_v_q     <= issue;
      fwd_v_q    <= ram_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_item_q <= mid_item_i;
    end
    fwd_addr_q <= ram_waddr;
    fwd_data_q <= ram_wdata;
  end

  dsh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (mid_item_i.bin[BIN_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  dsh_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_v_q),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (result_o),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

`ifndef NO_ASSERTIONS
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> !out_full)
    else $error("result queue full while a result is in flight");

  a_no_issue_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !issue && !s1_v_q)
    else $error("bin access during clearing pass");

  a_fwd_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> fwd_v_q && (fwd_addr_q == $past(ram_waddr)))
    else $error("forwarding register lost the last write");
`endif

endmodule
